// ----- hw/rtl/vna_pkg.sv -----
// Package for the vertex normal accumulator.
// Holds the item types, sizes and kind codes; depends on nothing.
package vna_pkg;

   localparam int VERTEX_COUNT = 4096;
   localparam int SUM_WIDTH    = 24;
   localparam int VADDR_W      = $clog2(VERTEX_COUNT);
   localparam int IDX_W        = 12;
   localparam int POS_W        = 16;
   localparam int NORM_W       = 16;
   localparam int EDGE_W       = POS_W + 1;
   localparam int PROD_W       = 2 * EDGE_W;
   // Wide enough for a cross product component and for a sum of SUM_WIDTH bits.
   localparam int VEC_W        = PROD_W + 1;
   localparam int MAG_W        = 30;
   localparam int SQ_W         = 2 * MAG_W + 2;
   localparam int LEN_W        = MAG_W + 1;
   localparam int Q_W          = 15;
   localparam int NUM_W        = MAG_W + 15;
   localparam int QDEPTH       = 4;
   localparam int QPTR_W       = $clog2(QDEPTH);

   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_FACE   = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]              kind;
      logic [IDX_W-1:0]        index_a;
      logic [IDX_W-1:0]        index_b;
      logic [IDX_W-1:0]        index_c;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]         vertex_index;
      logic signed [NORM_W-1:0] norm_x;
      logic signed [NORM_W-1:0] norm_y;
      logic signed [NORM_W-1:0] norm_z;
      logic                     zero_sum;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      req_type item;
   } queue_head_type;

   typedef struct packed {
      logic                     nonzero;
      logic signed [NORM_W-1:0] n_x;
      logic signed [NORM_W-1:0] n_y;
      logic signed [NORM_W-1:0] n_z;
   } norm_res_type;

   function automatic logic index_ok(input logic [IDX_W-1:0] idx);
      return ({20'd0, idx} < 32'(VERTEX_COUNT));
   endfunction

endpackage

// ----- hw/rtl/vna_front.sv -----
// Front end: accepts items and holds them in a short queue.
// Depends on vna_pkg.
module vna_front import vna_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  req_type        req_item,
   input  logic           pop,
   output queue_head_type head
);

   req_type            slot_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               push, do_pop;

   assign busy   = (count_ff == (QPTR_W+1)'(QDEPTH));
   assign push   = start && !busy;
   assign do_pop = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

// ----- hw/rtl/vna_norm.sv -----
// Iterative normalizer: scales a vector to a Q1.14 unit vector.
// Uses one squarer, a bit-pair square root and a restoring divider; depends on vna_pkg.
module vna_norm import vna_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [VEC_W-1:0] vec_x,
   input  logic signed [VEC_W-1:0] vec_y,
   input  logic signed [VEC_W-1:0] vec_z,
   output logic                    done,
   output norm_res_type            res
);

   localparam logic [2:0] N_IDLE  = 3'd0;
   localparam logic [2:0] N_SHIFT = 3'd1;
   localparam logic [2:0] N_SQ    = 3'd2;
   localparam logic [2:0] N_CHK   = 3'd3;
   localparam logic [2:0] N_SQRT  = 3'd4;
   localparam logic [2:0] N_DINIT = 3'd5;
   localparam logic [2:0] N_DIV   = 3'd6;
   localparam logic [2:0] N_DONE  = 3'd7;

   logic [2:0]              state_ff;
   logic [VEC_W-1:0]        mag_ff [3];
   logic                    neg_ff [3];
   logic [1:0]              comp_ff;
   logic [3:0]              step_ff;
   logic [SQ_W-1:0]         s_ff, r_ff, bit_ff;
   logic [LEN_W-1:0]        len_ff;
   logic [LEN_W:0]          rem_ff;
   logic [14:0]             low_ff;
   logic [Q_W-1:0]          q_ff;
   logic signed [NORM_W-1:0] n_ff [3];
   logic                    done_ff;
   norm_res_type            res_ff;

   logic signed [VEC_W-1:0] vin [3];
   logic                    wide;
   logic [MAG_W-1:0]        sq_op;
   logic [2*MAG_W-1:0]      sq_prod;
   logic [SQ_W-1:0]         sq_sum, rb;
   logic [NUM_W-1:0]        num;
   logic [LEN_W:0]          trial;
   logic [Q_W-1:0]          q_next;

   assign vin[0] = vec_x;
   assign vin[1] = vec_y;
   assign vin[2] = vec_z;
   assign done = done_ff;
   assign res  = res_ff;

   always_comb begin
      wide = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (mag_ff[i][VEC_W-1:MAG_W] != '0) wide = 1'b1;
      end
      sq_op   = mag_ff[comp_ff][MAG_W-1:0];
      sq_prod = sq_op * sq_op;
      sq_sum  = s_ff + SQ_W'(sq_prod);
      rb      = r_ff + bit_ff;
      num     = NUM_W'({mag_ff[comp_ff][MAG_W-1:0], 14'd0}) + NUM_W'(len_ff >> 1);
      trial   = {rem_ff[LEN_W-1:0], low_ff[14]};
      q_next  = {q_ff[Q_W-2:0], (trial >= {1'b0, len_ff})};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            N_IDLE: begin
               if (start) state_ff <= N_SHIFT;
            end
            N_SHIFT: begin
               if (!wide) state_ff <= N_SQ;
            end
            N_SQ: begin
               if (comp_ff == 2'd2) state_ff <= N_CHK;
            end
            N_CHK: begin
               state_ff <= (s_ff == '0) ? N_DONE : N_SQRT;
            end
            N_SQRT: begin
               if (bit_ff == '0) state_ff <= N_DINIT;
            end
            N_DINIT: begin
               state_ff <= N_DIV;
            end
            N_DIV: begin
               if (step_ff == 4'd14) state_ff <= (comp_ff == 2'd2) ? N_DONE : N_DINIT;
            end
            N_DONE: begin
               done_ff  <= 1'b1;
               state_ff <= N_IDLE;
            end
            default: state_ff <= N_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         N_IDLE: begin
            for (int i = 0; i < 3; i++) begin
               neg_ff[i] <= vin[i][VEC_W-1];
               mag_ff[i] <= vin[i][VEC_W-1] ? VEC_W'(-vin[i]) : VEC_W'(vin[i]);
            end
            comp_ff <= 2'd0;
            s_ff    <= '0;
         end
         N_SHIFT: begin
            if (wide) begin
               for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
            end
         end
         N_SQ: begin
            s_ff    <= sq_sum;
            comp_ff <= (comp_ff == 2'd2) ? 2'd0 : comp_ff + 2'd1;
         end
         N_CHK: begin
            r_ff   <= '0;
            bit_ff <= SQ_W'(1) << (SQ_W - 2);
            len_ff <= '0;
            for (int i = 0; i < 3; i++) n_ff[i] <= '0;
         end
         N_SQRT: begin
            if (bit_ff == '0) begin
               len_ff <= r_ff[LEN_W-1:0];
            end else begin
               if (s_ff >= rb) begin
                  s_ff <= s_ff - rb;
                  r_ff <= (r_ff >> 1) + bit_ff;
               end else begin
                  r_ff <= r_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
            end
         end
         N_DINIT: begin
            rem_ff  <= (LEN_W+1)'(num[NUM_W-1:15]);
            low_ff  <= num[14:0];
            q_ff    <= '0;
            step_ff <= '0;
         end
         N_DIV: begin
            rem_ff  <= (trial >= {1'b0, len_ff}) ? trial - {1'b0, len_ff} : trial;
            low_ff  <= {low_ff[13:0], 1'b0};
            q_ff    <= q_next;
            step_ff <= step_ff + 4'd1;
            if (step_ff == 4'd14) begin
               n_ff[comp_ff] <= neg_ff[comp_ff] ? -NORM_W'({1'b0, q_next})
                                                : NORM_W'({1'b0, q_next});
               comp_ff <= comp_ff + 2'd1;
            end
         end
         N_DONE: begin
            // A zero vector skips the square root, so its length stays at zero.
            res_ff.nonzero <= (len_ff != '0);
            res_ff.n_x     <= n_ff[0];
            res_ff.n_y     <= n_ff[1];
            res_ff.n_z     <= n_ff[2];
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- hw/rtl/vna_back.sv -----
// Back end: carries out loads, faces and queries against the vertex stores.
// Depends on vna_pkg and instantiates vna_norm.
module vna_back import vna_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   output logic           rsp_strobe,
   output rsp_type        rsp_item
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RA    = 4'd1;
   localparam logic [3:0] S_RB    = 4'd2;
   localparam logic [3:0] S_RC    = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_NSTRT = 4'd5;
   localparam logic [3:0] S_QRD   = 4'd6;
   localparam logic [3:0] S_NWAIT = 4'd7;
   localparam logic [3:0] S_ACCRD = 4'd8;
   localparam logic [3:0] S_ACCWR = 4'd9;

   localparam int PW = 3 * POS_W;
   localparam int SW = 3 * SUM_WIDTH;

   function automatic logic [SUM_WIDTH-1:0] sat_add(input logic [SUM_WIDTH-1:0] s,
                                                    input logic signed [NORM_W-1:0] n);
      logic [SUM_WIDTH:0] t;
      t = {s[SUM_WIDTH-1], s} + {{(SUM_WIDTH+1-NORM_W){n[NORM_W-1]}}, n};
      if (t[SUM_WIDTH] != t[SUM_WIDTH-1]) begin
         return t[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
      end
      return t[SUM_WIDTH-1:0];
   endfunction

   logic [PW-1:0] pos_mem [VERTEX_COUNT];
   logic [SW-1:0] sum_mem [VERTEX_COUNT];

   logic [3:0]               state_ff, state_in;
   req_type                  item_ff;
   logic [PW-1:0]            pos_rd_ff, pa_ff, pb_ff;
   logic [SW-1:0]            sum_rd_ff;
   logic signed [EDGE_W-1:0] e1_ff [3];
   logic signed [EDGE_W-1:0] e2_ff [3];
   logic signed [VEC_W-1:0]  cr_ff [3];
   logic [2:0]               mcnt_ff;
   logic [1:0]               vk_ff;
   norm_res_type             nres_ff;
   logic                     rsp_strobe_ff;
   rsp_type                  rsp_item_ff;

   logic                     pos_we, pos_re, sum_we, sum_re;
   logic [VADDR_W-1:0]       pos_waddr, pos_raddr, sum_waddr, sum_raddr;
   logic [PW-1:0]            pos_wdata;
   logic [SW-1:0]            sum_wdata;
   logic [IDX_W-1:0]         acc_idx;
   logic signed [EDGE_W-1:0] opa, opb;
   logic signed [PROD_W-1:0] prod;
   logic                     norm_start, norm_done;
   norm_res_type             norm_res;
   logic signed [VEC_W-1:0]  vx, vy, vz;
   logic                     face_ok;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;
   assign pop        = (state_ff == S_IDLE) && head.valid;
   assign face_ok    = index_ok(head.item.index_a) && index_ok(head.item.index_b)
                       && index_ok(head.item.index_c);

   always_comb begin
      case (vk_ff)
         2'd0:    acc_idx = item_ff.index_a;
         2'd1:    acc_idx = item_ff.index_b;
         default: acc_idx = item_ff.index_c;
      endcase
   end

   // Cross product operand schedule: two products per component.
   always_comb begin
      case (mcnt_ff)
         3'd0:    begin opa = e1_ff[1]; opb = e2_ff[2]; end
         3'd1:    begin opa = e1_ff[2]; opb = e2_ff[1]; end
         3'd2:    begin opa = e1_ff[2]; opb = e2_ff[0]; end
         3'd3:    begin opa = e1_ff[0]; opb = e2_ff[2]; end
         3'd4:    begin opa = e1_ff[0]; opb = e2_ff[1]; end
         default: begin opa = e1_ff[1]; opb = e2_ff[0]; end
      endcase
      prod = opa * opb;
   end

   always_comb begin
      if (state_ff == S_QRD) begin
         vx = VEC_W'(signed'(sum_rd_ff[SW-1 -: SUM_WIDTH]));
         vy = VEC_W'(signed'(sum_rd_ff[SW-1-SUM_WIDTH -: SUM_WIDTH]));
         vz = VEC_W'(signed'(sum_rd_ff[SUM_WIDTH-1:0]));
      end else begin
         vx = cr_ff[0];
         vy = cr_ff[1];
         vz = cr_ff[2];
      end
      norm_start = (state_ff == S_QRD) || (state_ff == S_NSTRT);
   end

   always_comb begin
      pos_we    = 1'b0;
      pos_re    = 1'b0;
      sum_we    = 1'b0;
      sum_re    = 1'b0;
      pos_waddr = VADDR_W'(head.item.index_a);
      pos_wdata = {head.item.pos_x, head.item.pos_y, head.item.pos_z};
      pos_raddr = VADDR_W'(head.item.index_a);
      sum_waddr = VADDR_W'(head.item.index_a);
      sum_wdata = '0;
      sum_raddr = VADDR_W'(head.item.index_a);
      state_in  = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               case (head.item.kind)
                  KIND_LOAD: begin
                     pos_we = index_ok(head.item.index_a);
                     sum_we = index_ok(head.item.index_a);
                  end
                  KIND_FACE: begin
                     if (face_ok) begin
                        pos_re   = 1'b1;
                        state_in = S_RA;
                     end
                  end
                  KIND_QUERY: begin
                     if (index_ok(head.item.index_a)) begin
                        sum_re   = 1'b1;
                        state_in = S_QRD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RA: begin
            pos_re    = 1'b1;
            pos_raddr = VADDR_W'(item_ff.index_b);
            state_in  = S_RB;
         end
         S_RB: begin
            pos_re    = 1'b1;
            pos_raddr = VADDR_W'(item_ff.index_c);
            state_in  = S_RC;
         end
         S_RC:    state_in = S_MUL;
         S_MUL:   state_in = (mcnt_ff == 3'd5) ? S_NSTRT : S_MUL;
         S_NSTRT: state_in = S_NWAIT;
         S_QRD:   state_in = S_NWAIT;
         S_NWAIT: begin
            if (norm_done) begin
               state_in = (item_ff.kind == KIND_FACE && norm_res.nonzero) ? S_ACCRD : S_IDLE;
            end
         end
         S_ACCRD: begin
            sum_re    = 1'b1;
            sum_raddr = VADDR_W'(acc_idx);
            state_in  = S_ACCWR;
         end
         S_ACCWR: begin
            sum_we    = 1'b1;
            sum_waddr = VADDR_W'(acc_idx);
            sum_wdata = {sat_add(sum_rd_ff[SW-1 -: SUM_WIDTH], nres_ff.n_x),
                         sat_add(sum_rd_ff[SW-1-SUM_WIDTH -: SUM_WIDTH], nres_ff.n_y),
                         sat_add(sum_rd_ff[SUM_WIDTH-1:0], nres_ff.n_z)};
            state_in  = (vk_ff == 2'd2) ? S_IDLE : S_ACCRD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
      if (pos_re) pos_rd_ff <= pos_mem[pos_raddr];
   end

   always_ff @(posedge clock) begin
      if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
      if (sum_re) sum_rd_ff <= sum_mem[sum_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= 1'b0;
         if (state_ff == S_IDLE && head.valid && head.item.kind == KIND_QUERY
             && !index_ok(head.item.index_a)) begin
            rsp_strobe_ff <= 1'b1;
         end
         if (state_ff == S_NWAIT && norm_done && item_ff.kind == KIND_QUERY) begin
            rsp_strobe_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            item_ff <= head.item;
            rsp_item_ff.vertex_index <= head.item.index_a;
            rsp_item_ff.norm_x       <= '0;
            rsp_item_ff.norm_y       <= '0;
            rsp_item_ff.norm_z       <= '0;
            rsp_item_ff.zero_sum     <= 1'b1;
         end
         S_RA: pa_ff <= pos_rd_ff;
         S_RB: pb_ff <= pos_rd_ff;
         S_RC: begin
            for (int i = 0; i < 3; i++) begin
               e1_ff[i] <= EDGE_W'(signed'(pb_ff[PW-1-i*POS_W -: POS_W]))
                         - EDGE_W'(signed'(pa_ff[PW-1-i*POS_W -: POS_W]));
               e2_ff[i] <= EDGE_W'(signed'(pos_rd_ff[PW-1-i*POS_W -: POS_W]))
                         - EDGE_W'(signed'(pa_ff[PW-1-i*POS_W -: POS_W]));
            end
            mcnt_ff <= 3'd0;
         end
         S_MUL: begin
            if (mcnt_ff[0]) begin
               cr_ff[mcnt_ff[2:1]] <= cr_ff[mcnt_ff[2:1]] - VEC_W'(prod);
            end else begin
               cr_ff[mcnt_ff[2:1]] <= VEC_W'(prod);
            end
            mcnt_ff <= mcnt_ff + 3'd1;
         end
         S_NWAIT: begin
            if (norm_done) begin
               nres_ff <= norm_res;
               vk_ff   <= 2'd0;
               rsp_item_ff.norm_x   <= norm_res.n_x;
               rsp_item_ff.norm_y   <= norm_res.n_y;
               rsp_item_ff.norm_z   <= norm_res.n_z;
               rsp_item_ff.zero_sum <= !norm_res.nonzero;
            end
         end
         S_ACCWR: vk_ff <= vk_ff + 2'd1;
         default: begin
         end
      endcase
   end

   vna_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (norm_start),
      .vec_x (vx),
      .vec_y (vy),
      .vec_z (vz),
      .done  (norm_done),
      .res   (norm_res)
   );

endmodule

// ----- hw/rtl/vertex_normal_accumulator.sv -----
// Vertex normal accumulator: smooth per-vertex normals from averaged unit face normals.
// The back end works on one item at a time. A load is written from its idle state; a face or
// an in-range query goes through the normalizer: 31 square root steps plus 15 divide steps
// per axis, skipped for a zero normal or zero sum. An out-of-range query skips the normalizer.
// A four-item queue takes start meanwhile; reset (synchronous) empties it, idles both ends
// and leaves the stores as they are. Results are one-cycle strobes that cannot be stalled.
module vertex_normal_accumulator import vna_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   // The queue head and its pop travel between the front and back ends.
   queue_head_type head;
   logic           pop;

   // The front end only buffers items; busy rises when its queue is full.
   vna_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .pop      (pop),
      .head     (head)
   );

   // The back end owns the position and sum stores and the normalizer.
   vna_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

// ----- tb/vna_checker.sv -----
`timescale 1ns / 1ps
// Checker for the vertex normal accumulator: watches both channels and predicts query results.
// Depends on vna_pkg for the item types and kind codes.
module vna_checker import vna_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_strobe,
   input  rsp_type rsp_item,
   output int      errors,
   output int      pending
);

   typedef struct {
      bit ok;
      int n[3];
   } unit_vec_type;

   localparam int SUM_HI = (1 << (SUM_WIDTH - 1)) - 1;
   localparam int SUM_LO = -(1 << (SUM_WIDTH - 1));

   int        vx [VERTEX_COUNT];
   int        vy [VERTEX_COUNT];
   int        vz [VERTEX_COUNT];
   int        acc_x [VERTEX_COUNT];
   int        acc_y [VERTEX_COUNT];
   int        acc_z [VERTEX_COUNT];
   rsp_type   normal_q[$];

   function automatic unit_vec_type to_unit(longint cx, longint cy, longint cz);
      longint             v[3];
      longint unsigned    m[3];
      bit                 ng[3];
      longint unsigned    mx, s, len, cand, q;
      int                 sh;
      unit_vec_type       u;
      v = '{cx, cy, cz};
      mx = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         ng[i] = v[i] < 0;
         m[i] = ng[i] ? longint'(-v[i]) : longint'(v[i]);
         if (m[i] > mx) mx = m[i];
      end
      sh = 0;
      while ((mx >> sh) >= (64'd1 << 30)) sh++;
      for (int i = 0; i < 3; i++) begin
         m[i] = m[i] >> sh;
         s += m[i] * m[i];
      end
      u.n = '{0, 0, 0};
      u.ok = (s != 0);
      if (u.ok) begin
         // Integer square root, one result bit at a time from the top.
         len = 0;
         for (int b = 31; b >= 0; b--) begin
            cand = len | (64'd1 << b);
            if (cand * cand <= s) len = cand;
         end
         for (int i = 0; i < 3; i++) begin
            q = (m[i] * 64'd16384 + len / 2) / len;
            u.n[i] = ng[i] ? -int'(q) : int'(q);
         end
      end
      return u;
   endfunction

   function automatic int sat_sum(int s, int d);
      longint t;
      t = longint'(s) + d;
      if (t > SUM_HI) t = SUM_HI;
      if (t < SUM_LO) t = SUM_LO;
      return int'(t);
   endfunction

   task automatic apply_item(req_type r);
      longint       e1[3], e2[3];
      int           idx[3];
      unit_vec_type u;
      rsp_type      exp_rsp;
      case (r.kind)
         KIND_LOAD: begin
            if (r.index_a < VERTEX_COUNT) begin
               vx[r.index_a] = r.pos_x;
               vy[r.index_a] = r.pos_y;
               vz[r.index_a] = r.pos_z;
               acc_x[r.index_a] = 0;
               acc_y[r.index_a] = 0;
               acc_z[r.index_a] = 0;
            end
         end
         KIND_FACE: begin
            idx = '{r.index_a, r.index_b, r.index_c};
            if (idx[0] < VERTEX_COUNT && idx[1] < VERTEX_COUNT && idx[2] < VERTEX_COUNT) begin
               e1 = '{vx[idx[1]] - vx[idx[0]], vy[idx[1]] - vy[idx[0]], vz[idx[1]] - vz[idx[0]]};
               e2 = '{vx[idx[2]] - vx[idx[0]], vy[idx[2]] - vy[idx[0]], vz[idx[2]] - vz[idx[0]]};
               u = to_unit(e1[1] * e2[2] - e1[2] * e2[1],
                           e1[2] * e2[0] - e1[0] * e2[2],
                           e1[0] * e2[1] - e1[1] * e2[0]);
               if (u.ok) begin
                  for (int k = 0; k < 3; k++) begin
                     acc_x[idx[k]] = sat_sum(acc_x[idx[k]], u.n[0]);
                     acc_y[idx[k]] = sat_sum(acc_y[idx[k]], u.n[1]);
                     acc_z[idx[k]] = sat_sum(acc_z[idx[k]], u.n[2]);
                  end
               end
            end
         end
         KIND_QUERY: begin
            u.ok = 0;
            u.n = '{0, 0, 0};
            if (r.index_a < VERTEX_COUNT)
               u = to_unit(acc_x[r.index_a], acc_y[r.index_a], acc_z[r.index_a]);
            exp_rsp.vertex_index = r.index_a;
            exp_rsp.norm_x = u.n[0][NORM_W-1:0];
            exp_rsp.norm_y = u.n[1][NORM_W-1:0];
            exp_rsp.norm_z = u.n[2][NORM_W-1:0];
            exp_rsp.zero_sum = !u.ok;
            normal_q = {normal_q, exp_rsp};
         end
         default: ;
      endcase
   endtask

   task automatic report(string what, rsp_type want, rsp_type got);
      errors++;
      if (errors <= 10)
         $display({"vna_checker: %s: expected idx %0d n %0d %0d %0d z %0d,",
                   " got idx %0d n %0d %0d %0d z %0d"},
                  what, want.vertex_index, want.norm_x, want.norm_y, want.norm_z,
                  want.zero_sum, got.vertex_index, got.norm_x, got.norm_y, got.norm_z,
                  got.zero_sum);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         // A result and the item that predicts it cannot share an edge, so check first.
         if (rsp_strobe) begin
            if (normal_q.size() == 0) begin
               want = '0;
               report("result with none expected", want, rsp_item);
            end else begin
               want = normal_q.pop_front();
               if (rsp_item.vertex_index !== want.vertex_index ||
                   rsp_item.norm_x !== want.norm_x || rsp_item.norm_y !== want.norm_y ||
                   rsp_item.norm_z !== want.norm_z || rsp_item.zero_sum !== want.zero_sum)
                  report("mismatch", want, rsp_item);
            end
         end
         if (start && !busy) apply_item(req_item);
      end
      pending = normal_q.size();
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the vertex normal accumulator testbench: clock, reset, stimulus and verdict.
// Depends on vna_pkg, vertex_normal_accumulator and vna_checker.
module tb_top;
   import vna_pkg::*;

   // No acceptance on either channel for this many cycles ends the run.
   localparam int WATCHDOG_LIMIT = 4000;

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;
   int      errors;
   int      pending;

   int      stall_count = 0;
   bit      gaps_on = 1;
   // Vertices that have been loaded; faces and queries name only these, so that no
   // store entry is ever read before it is written.
   int      loaded_list[$];
   bit      is_loaded [VERTEX_COUNT];

   always #2 clock = ~clock;

   vertex_normal_accumulator u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   vna_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .errors     (errors),
      .pending    (pending)
   );

   // The watchdog restarts on every accepted item and on every result.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count >= WATCHDOG_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   // Present one item and hold it until the block takes it. Start stays high when the
   // next item follows at once, so it is never lowered and raised in the same step.
   task automatic send(req_type r);
      req_item <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if (r.kind == KIND_LOAD && !is_loaded[r.index_a]) begin
         is_loaded[r.index_a] = 1;
         loaded_list = {loaded_list, int'(r.index_a)};
      end
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // Every field starts random, so the fields a kind ignores still see both bit values.
   function automatic req_type noise_item(logic [1:0] kind);
      logic [95:0] raw;
      req_type     r;
      raw = {$urandom, $urandom, $urandom};
      r = raw[$bits(req_type)-1:0];
      r.kind = kind;
      return r;
   endfunction

   function automatic req_type load_item(int idx, int x, int y, int z);
      req_type r;
      r = noise_item(KIND_LOAD);
      r.index_a = IDX_W'(idx);
      r.pos_x = POS_W'(x);
      r.pos_y = POS_W'(y);
      r.pos_z = POS_W'(z);
      return r;
   endfunction

   function automatic req_type face_item(int a, int b, int c);
      req_type r;
      r = noise_item(KIND_FACE);
      r.index_a = IDX_W'(a);
      r.index_b = IDX_W'(b);
      r.index_c = IDX_W'(c);
      return r;
   endfunction

   function automatic req_type query_item(int a);
      req_type r;
      r = noise_item(KIND_QUERY);
      r.index_a = IDX_W'(a);
      return r;
   endfunction

   function automatic int pick_loaded();
      return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
   endfunction

   initial begin
      int      pick, a, b, c;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: extreme indices and coordinates, a query on a freshly cleared
      // sum, faces with a repeated vertex and with collinear vertices, and an unused kind.
      send(load_item(0, 0, 0, 0));
      send(load_item(4095, 32767, 32767, 32767));
      send(load_item(1, -32768, -32768, -32768));
      send(load_item(2, 32767, -32768, 0));
      send(query_item(0));
      send(face_item(0, 0, 4095));
      send(face_item(0, 1, 2));
      send(face_item(4095, 1, 2));
      send(query_item(0));
      send(query_item(1));
      send(query_item(2));
      send(query_item(4095));
      send(noise_item(KIND_UNUSED));
      send(load_item(5, 100, 100, 100));
      send(load_item(6, 200, 200, 200));
      send(face_item(0, 5, 6));
      send(query_item(5));
      send(load_item(1, -1, 1, -1));
      send(query_item(1));

      // Saturation: one triangle with a unit normal along z, repeated until its sums pin
      // at the top of the signed range, then one face of the opposite winding.
      send(load_item(10, 0, 0, 0));
      send(load_item(11, 16384, 0, 0));
      send(load_item(12, 0, 16384, 0));
      for (int i = 0; i < 514; i++) begin
         send(face_item(10, 11, 12));
      end
      send(query_item(10));
      send(face_item(10, 12, 11));
      send(query_item(10));

      // Random part: mostly faces and queries over loaded vertices, with some reloads
      // and a little noise of the unused kind.
      for (int i = 0; i < 80; i++) begin
         if (i == 40) begin
            // Let every expected query result come back once before going on.
            start <= 1'b0;
            do @(posedge clock); while (pending != 0);
         end
         if (i == 60) gaps_on = 0;
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            send(load_item($urandom_range(0, VERTEX_COUNT - 1),
                           $urandom_range(0, 9) < 3 ? int'($urandom_range(0, 65535)) - 32768
                                                    : int'($urandom_range(0, 4095)) - 2048,
                           int'($urandom_range(0, 65535)) - 32768,
                           int'($urandom_range(0, 65535)) - 32768));
         end else if (pick < 65) begin
            a = pick_loaded();
            b = pick_loaded();
            c = ($urandom_range(0, 9) == 0) ? a : pick_loaded();
            send(face_item(a, b, c));
         end else if (pick < 92) begin
            send(query_item(pick_loaded()));
         end else begin
            send(noise_item(KIND_UNUSED));
         end
      end
      start <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (400) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
